>>> sv/bvm_pkg.sv
`default_nettype none

package bvm_pkg;

    // averaging store and easing
    localparam int AVG_DEPTH      = 8;
    localparam int POS_W          = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int MV_W           = 16;
    localparam int SUM_W          = MV_W + ((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0);
    localparam int EASE_PERIOD_MS = 500;
    localparam int TIME_W         = 32;

    // scaling constants
    localparam int TUNE_SCALE     = 1000;
    localparam int NOMINAL_RESET  = 3700;
    localparam int MV_MAX         = 65535;

    // configuration register widths
    localparam int VREF_W   = 13;
    localparam int FS_W     = 16;
    localparam int RES_W    = 20;
    localparam int TUNE_W   = 12;
    localparam int IVL_W    = 16;
    localparam int CFG_DW   = 20;
    localparam int CFG_IDX_W = 3;

    // configuration reset values
    localparam int VREF_RESET = 3300;
    localparam int FS_RESET   = 1024;
    localparam int RL_RESET   = 10000;
    localparam int RU_RESET   = 10000;
    localparam int TUNE_RESET = 1000;
    localparam int IVL_RESET  = 20;

    // datapath widths of the serial units
    localparam int ADC_W   = 16;
    localparam int T0_W    = VREF_W + ADC_W;          // vref * adc and its quotient
    localparam int T1_W    = RES_W + 1 + TUNE_W;      // (rl + ru) * tune and its quotient
    localparam int DVD_W   = T1_W;                    // widest dividend
    localparam int DVR_W   = RES_W;                   // widest divisor
    localparam int PROD_W  = T0_W + T1_W;             // t0 * t1
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int MUL_CNT_W = $clog2(T1_W + 1);

    // t0 * t1 at or above this saturates the scaled value
    localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(64'(MV_MAX + 1) * 64'(TUNE_SCALE));
    localparam int SCALE_DVD_W = $clog2(64'(MV_MAX + 1) * 64'(TUNE_SCALE));

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VREF_MV    = 3'd0,
        CFG_FULL_SCALE = 3'd1,
        CFG_R_LOWER    = 3'd2,
        CFG_R_UPPER    = 3'd3,
        CFG_TUNE_MILLI = 3'd4,
        CFG_NOMINAL_MV = 3'd5,
        CFG_INTERVAL   = 3'd6
    } t_cfg_idx;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

>>> sv/bvm_serial_div.sv
`default_nettype none

module bvm_serial_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bvm_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [bvm_pkg::DVR_W-1:0]  i_divisor,
    output bvm_pkg::t_unit_stat             o_stat,
    output logic      [bvm_pkg::DVD_W-1:0]  o_quotient
);
    import bvm_pkg::*;

    logic [DVD_W-1:0]     r_quo;
    logic [DVR_W-1:0]     r_rem;
    logic [DVR_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DVR_W:0]       w_trial;
    logic [DVR_W+1:0]     w_diff;
    logic                 w_ge;

    // restoring step: one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_div};
    assign w_ge    = ~w_diff[DVR_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= DIV_CNT_W'(DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[DVD_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DVR_W-1:0] : w_trial[DVR_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

    // a running division keeps a step count
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider busy with no steps left");

    // partial remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_div)
        else $error("divider remainder out of range");

    // done follows the last step
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && $past(r_cnt) == DIV_CNT_W'(1))
        else $error("divider done without a last step");

endmodule

`default_nettype wire

>>> sv/bvm_serial_mul.sv
`default_nettype none

module bvm_serial_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [bvm_pkg::T0_W-1:0]    i_a,
    input  wire logic [bvm_pkg::T1_W-1:0]    i_b,
    output bvm_pkg::t_unit_stat              o_stat,
    output logic      [bvm_pkg::PROD_W-1:0]  o_product
);
    import bvm_pkg::*;

    logic [PROD_W-1:0]    r_p;
    logic [T0_W-1:0]      r_a;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [T0_W:0]        w_sum;

    // shift-add on the multiplier bits, lsb first
    assign w_sum = {1'b0, r_p[PROD_W-1:T1_W]} + (r_p[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_p    <= {{T0_W{1'b0}}, i_b};
                r_a    <= i_a;
                r_cnt  <= MUL_CNT_W'(T1_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_p   <= {w_sum, r_p[T1_W-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_p;

endmodule

`default_nettype wire

>>> sv/battery_voltage_monitor.sv
// Battery voltage monitor. Each input beat is a tick with a millisecond time and a raw
// ADC reading; each tick gives exactly one output beat. A tick whose time is at least
// the sample interval past the last sample is scaled to millivolts (vref * adc / full
// scale, times (r_lower + r_upper) * tune / r_lower, over 1000, saturated at 65535),
// pushed into an 8-entry moving average, and at most every 500 ms the eased output
// takes the average. A tick that takes no sample goes from the check state straight
// to emit; a sampling tick goes through load, divide, multiply and scale, with three
// 33-step passes through the one-bit-per-cycle divider and multiplier (two divisions
// side by side, the product, then the division by 1000). One tick is worked at a time;
// a finished beat sits in the output register while the next tick is accepted.
// Configuration writes take effect at once and are made, by the user's rule, while no
// tick is in flight; the block itself leaves this to the user. A nominal write does not refill the average store.
`default_nettype none

module battery_voltage_monitor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_wen,
    input  wire logic [bvm_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [bvm_pkg::CFG_DW-1:0]     i_cfg_wdata,
    // tick input
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [bvm_pkg::TIME_W-1:0]     i_now_ms,
    input  wire logic [bvm_pkg::ADC_W-1:0]      i_adc_sample,
    // result output
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [bvm_pkg::MV_W-1:0]       o_eased_mv,
    output logic      [bvm_pkg::MV_W-1:0]       o_latest_mv,
    output logic                                o_sampled
);
    import bvm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_SCALE,
        S_EMIT
    } t_state;

    // configuration registers
    logic [VREF_W-1:0] r_vref_mv;
    logic [FS_W-1:0]   r_full_scale;
    logic [RES_W-1:0]  r_r_lower;
    logic [RES_W-1:0]  r_r_upper;
    logic [TUNE_W-1:0] r_tune_milli;
    logic [MV_W-1:0]   r_nominal_mv;
    logic [IVL_W-1:0]  r_interval;

    // sequencer and tick state
    t_state              r_state;
    logic [TIME_W-1:0]   r_now;
    logic [ADC_W-1:0]    r_adc;
    logic                r_take;
    logic [T0_W-1:0]     r_prod0;
    logic [T1_W-1:0]     r_prod1;
    logic                r_sat;
    logic [MV_W-1:0]     r_v;
    logic [MV_W-1:0]     r_ring [AVG_DEPTH];
    logic [POS_W-1:0]    r_pos;
    logic [SUM_W-1:0]    r_sum;
    logic [TIME_W-1:0]   r_last_sample;
    logic [TIME_W-1:0]   r_last_ease;
    logic [MV_W-1:0]     r_eased;
    logic [MV_W-1:0]     r_latest;
    logic                r_out_valid;
    logic                r_o_sampled;

    // serial unit hookup
    t_unit_stat          w_d0_stat;
    t_unit_stat          w_d1_stat;
    t_unit_stat          w_mul_stat;
    logic [DVD_W-1:0]    w_q0;
    logic [DVD_W-1:0]    w_q1;
    logic [PROD_W-1:0]   w_product;
    logic                w_d0_start;
    logic                w_d1_start;
    logic                w_mul_start;
    logic [DVD_W-1:0]    w_d0_dividend;
    logic [DVR_W-1:0]    w_d0_divisor;
    logic [DVR_W-1:0]    w_d1_divisor;

    logic [TIME_W-1:0]   w_since_sample;
    logic [TIME_W-1:0]   w_since_ease;
    logic                w_in_beat;
    logic                w_emit;
    logic [SUM_W-1:0]    w_new_sum;
    logic [POS_W-1:0]    w_next_pos;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vref_mv    <= VREF_W'(VREF_RESET);
            r_full_scale <= FS_W'(FS_RESET);
            r_r_lower    <= RES_W'(RL_RESET);
            r_r_upper    <= RES_W'(RU_RESET);
            r_tune_milli <= TUNE_W'(TUNE_RESET);
            r_nominal_mv <= MV_W'(NOMINAL_RESET);
            r_interval   <= IVL_W'(IVL_RESET);
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                CFG_VREF_MV:    r_vref_mv    <= i_cfg_wdata[VREF_W-1:0];
                CFG_FULL_SCALE: r_full_scale <= i_cfg_wdata[FS_W-1:0];
                CFG_R_LOWER:    r_r_lower    <= i_cfg_wdata[RES_W-1:0];
                CFG_R_UPPER:    r_r_upper    <= i_cfg_wdata[RES_W-1:0];
                CFG_TUNE_MILLI: r_tune_milli <= i_cfg_wdata[TUNE_W-1:0];
                CFG_NOMINAL_MV: r_nominal_mv <= i_cfg_wdata[MV_W-1:0];
                CFG_INTERVAL:   r_interval   <= i_cfg_wdata[IVL_W-1:0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_emit     = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // elapsed times, wrapping
    assign w_since_sample = r_now - r_last_sample;
    assign w_since_ease   = r_now - r_last_ease;

    // divider 0 does vref*adc / full scale, then the product / 1000
    assign w_d0_start    = (r_state == S_LOAD) || ((r_state == S_MUL) && w_mul_stat.done);
    assign w_d0_dividend = (r_state == S_LOAD) ? DVD_W'(r_prod0)
                                               : DVD_W'(w_product[SCALE_DVD_W-1:0]);
    assign w_d0_divisor  = (r_state == S_LOAD)
                         ? ((r_full_scale == '0) ? DVR_W'(1) : DVR_W'(r_full_scale))
                         : DVR_W'(TUNE_SCALE);

    // divider 1 does (rl + ru) * tune / rl
    assign w_d1_start   = (r_state == S_LOAD);
    assign w_d1_divisor = (r_r_lower == '0) ? DVR_W'(1) : r_r_lower;

    assign w_mul_start = (r_state == S_DIV) && w_d0_stat.done;

    bvm_serial_div u_div0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_d0_start),
        .i_dividend (w_d0_dividend),
        .i_divisor  (w_d0_divisor),
        .o_stat     (w_d0_stat),
        .o_quotient (w_q0)
    );

    bvm_serial_div u_div1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_d1_start),
        .i_dividend (r_prod1),
        .i_divisor  (w_d1_divisor),
        .o_stat     (w_d1_stat),
        .o_quotient (w_q1)
    );

    bvm_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_q0[T0_W-1:0]),
        .i_b       (w_q1),
        .o_stat    (w_mul_stat),
        .o_product (w_product)
    );

    // running sum and ring position after this sample
    assign w_new_sum  = r_sum - SUM_W'(r_ring[r_pos]) + SUM_W'(r_v);
    assign w_next_pos = (r_pos == POS_W'(AVG_DEPTH - 1)) ? '0 : r_pos + 1'b1;

    // sequencer, averaging store and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_o_sampled   <= 1'b0;
            r_take        <= 1'b0;
            r_pos         <= '0;
            r_sum         <= SUM_W'(AVG_DEPTH * NOMINAL_RESET);
            r_last_sample <= '0;
            r_last_ease   <= '0;
            r_eased       <= MV_W'(NOMINAL_RESET);
            r_latest      <= MV_W'(NOMINAL_RESET);
            for (int i = 0; i < AVG_DEPTH; i++) begin
                r_ring[i] <= MV_W'(NOMINAL_RESET);
            end
        end else begin
            if (r_out_valid && i_out_ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_now   <= i_now_ms;
                        r_adc   <= i_adc_sample;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_prod0 <= T0_W'(r_vref_mv) * T0_W'(r_adc);
                    r_prod1 <= T1_W'({1'b0, r_r_lower} + {1'b0, r_r_upper})
                             * T1_W'(r_tune_milli);
                    if (w_since_sample >= TIME_W'(r_interval)) begin
                        r_take  <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_take  <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_d0_stat.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_stat.done) begin
                        r_sat   <= (w_product >= SAT_LIMIT);
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (w_d0_stat.done) begin
                        r_v     <= r_sat ? MV_W'(MV_MAX) : w_q0[MV_W-1:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        if (r_take) begin
                            r_last_sample  <= r_now;
                            r_latest       <= r_v;
                            r_sum          <= w_new_sum;
                            r_ring[r_pos]  <= r_v;
                            r_pos          <= w_next_pos;
                            if (w_since_ease >= TIME_W'(EASE_PERIOD_MS)) begin
                                r_last_ease <= r_now;
                                r_eased     <= MV_W'(w_new_sum / AVG_DEPTH);
                            end
                        end
                        r_o_sampled <= r_take;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_eased_mv  = r_eased;
    assign o_latest_mv = r_latest;
    assign o_sampled   = r_o_sampled;

    // the ring only moves on a sampling beat
    a_pos_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_pos) |-> $past(w_emit) && $past(r_take))
        else $error("ring position moved without a sample");

    // a beat that takes no sample leaves the latest value alone
    a_latest_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && !r_take |=> $stable(r_latest))
        else $error("latest value changed on a tick without a sample");

    // both dividers run in lockstep during the first pass
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_d0_stat.busy == w_d1_stat.busy)
                             && (w_d0_stat.done == w_d1_stat.done))
        else $error("dividers out of step");

    // a new output beat comes only from the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("output beat raised outside the emit step");

endmodule

`default_nettype wire
